@@ hw/rtl/fwpid_pkg.sv @@
package fwpid_pkg;

  localparam int NUM_WHEELS  = 4;
  localparam int WHEEL_W     = 2;
  localparam int FRAC_BITS   = 8;
  localparam int COUNT_WRAP  = 30000;
  localparam int ERR_W       = 28;
  localparam int SUM_W       = 40;
  localparam int ACC_W       = 58;
  localparam int MUL_W       = 16;
  localparam int STEP_W      = 4;
  localparam int SPEED_SHIFT = 16 - FRAC_BITS;
  localparam int OUT_SHIFT   = 8 + FRAC_BITS;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP      = 3'd0,
    REG_GAIN_INTEG     = 3'd1,
    REG_GAIN_DERIV     = 3'd2,
    REG_DRIVE_LIMIT    = 3'd3,
    REG_COUNT_TO_SPEED = 3'd4,
    REG_DERIV_WINDOW   = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPEED,
    S_SPD_WAIT,
    S_ERR,
    S_P_WAIT,
    S_I_WAIT,
    S_D_WAIT,
    S_FIN,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic                    start;
    logic                    clear;
    logic signed [ACC_W-1:0] mcand;
    logic [MUL_W-1:0]        mplier;
  } mac_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_sts_t;

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [32:0] x);
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    hi = 33'sd134217727;
    lo = -33'sd134217728;
    if (x > hi) return hi[ERR_W-1:0];
    if (x < lo) return lo[ERR_W-1:0];
    return x[ERR_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] x);
    logic signed [SUM_W:0] hi;
    logic signed [SUM_W:0] lo;
    hi = {2'b00, {(SUM_W-1){1'b1}}};
    lo = {2'b11, {(SUM_W-1){1'b0}}};
    if (x > hi) return hi[SUM_W-1:0];
    if (x < lo) return lo[SUM_W-1:0];
    return x[SUM_W-1:0];
  endfunction

endpackage

@@ hw/rtl/four_wheel_pid_speed_control.sv @@
// throughput: one tick at a time; in_stall stays high from accept until the result is loaded,
// so no new tick is taken while one is in progress; a stalled output beat holds off the load
// the bit-serial multiplier (3 or 4 products per wheel, the fourth only when the derivative
// term is active) sets the rate
// reset: synchronous active-low rst_n clears error history, sums, control and restores
// register defaults
module four_wheel_pid_speed_control
  import fwpid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [15:0]    in_enc_count_0,
  input  logic signed [15:0]    in_enc_count_1,
  input  logic signed [15:0]    in_enc_count_2,
  input  logic signed [15:0]    in_enc_count_3,
  input  logic signed [15:0]    in_target_0,
  input  logic signed [15:0]    in_target_1,
  input  logic signed [15:0]    in_target_2,
  input  logic signed [15:0]    in_target_3,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    out_drive_0,
  output logic signed [15:0]    out_drive_1,
  output logic signed [15:0]    out_drive_2,
  output logic signed [15:0]    out_drive_3
);

  // configuration registers
  logic [15:0] gain_prop_r, gain_integ_r, gain_deriv_r, deriv_window_r;
  logic [14:0] drive_limit_r;
  logic [23:0] count_to_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r      <= 16'd614;
      gain_integ_r     <= 16'd256;
      gain_deriv_r     <= 16'd0;
      drive_limit_r    <= 15'd999;
      count_to_speed_r <= 24'd212323;
      deriv_window_r   <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GAIN_PROP:      gain_prop_r      <= cfg_wdata[15:0];
        REG_GAIN_INTEG:     gain_integ_r     <= cfg_wdata[15:0];
        REG_GAIN_DERIV:     gain_deriv_r     <= cfg_wdata[15:0];
        REG_DRIVE_LIMIT:    drive_limit_r    <= cfg_wdata[14:0];
        REG_COUNT_TO_SPEED: count_to_speed_r <= cfg_wdata[23:0];
        REG_DERIV_WINDOW:   deriv_window_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  fsm_t                state_r, state_nxt;
  logic [WHEEL_W-1:0]  wheel_r;
  logic                rneg_r;
  logic                out_valid_r;

  // latched input beat
  logic signed [15:0]  cnt_r [NUM_WHEELS];
  logic signed [15:0]  tgt_r [NUM_WHEELS];

  // per-wheel pid history
  logic signed [ERR_W-1:0] err_now_r   [NUM_WHEELS];
  logic signed [ERR_W-1:0] err_prev_r  [NUM_WHEELS];
  logic signed [ERR_W-1:0] err_prev2_r [NUM_WHEELS];
  logic signed [SUM_W-1:0] err_sum_r   [NUM_WHEELS];

  logic signed [15:0] drv_r  [NUM_WHEELS];
  logic signed [15:0] dout_r [NUM_WHEELS];

  mac_req_t                mac_req;
  mac_sts_t                mac_sts;
  logic signed [ACC_W-1:0] mac_acc;

  fwpid_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .sts   (mac_sts),
    .acc   (mac_acc)
  );

  wire in_acc   = in_valid && !in_stall;
  wire out_free = !out_valid_r || !out_stall;

  // truncating remainder by the wrap count: one compare and correction
  logic signed [15:0] cnt_cur, rem;
  logic [15:0]        rem_mag;
  always_comb begin
    cnt_cur = cnt_r[wheel_r];
    if (cnt_cur >= 16'(COUNT_WRAP))       rem = cnt_cur - 16'(COUNT_WRAP);
    else if (cnt_cur <= -16'(COUNT_WRAP)) rem = cnt_cur + 16'(COUNT_WRAP);
    else                                  rem = cnt_cur;
    rem_mag = rem[15] ? 16'(-rem) : rem;
  end

  // error from the speed product; magnitude shift keeps truncation toward zero
  logic [30:0]             spd_mag;
  logic signed [31:0]      speed;
  logic signed [23:0]      tgt_q;
  logic signed [32:0]      diff;
  logic signed [ERR_W-1:0] e_new;
  logic signed [SUM_W-1:0] sum_new;
  always_comb begin
    spd_mag = mac_acc[SPEED_SHIFT +: 31];
    speed   = rneg_r ? -$signed({1'b0, spd_mag}) : $signed({1'b0, spd_mag});
    tgt_q   = {tgt_r[wheel_r], {FRAC_BITS{1'b0}}};
    diff    = 33'(tgt_q) - 33'(speed);
    e_new   = sat_err(diff);
    sum_new = sat_sum(41'(err_sum_r[wheel_r]) + 41'(e_new));
  end

  // derivative operand and window test
  logic signed [30:0] d_term;
  logic               d_on;
  always_comb begin
    d_term = 31'(err_now_r[wheel_r]) - (31'(err_prev_r[wheel_r]) <<< 1)
           + 31'(err_prev2_r[wheel_r]);
    d_on   = 29'(err_now_r[wheel_r]) < $signed({5'b0, deriv_window_r, {FRAC_BITS{1'b0}}});
  end

  // pid sum to integer (toward zero) and clamp
  logic signed [ACC_W-1:0]           biased;
  logic signed [ACC_W-OUT_SHIFT-1:0] val, lim;
  logic signed [15:0]                drv_val;
  always_comb begin
    biased = mac_acc + (mac_acc[ACC_W-1] ? ACC_W'({OUT_SHIFT{1'b1}}) : '0);
    val    = biased[ACC_W-1:OUT_SHIFT];
    lim    = (ACC_W-OUT_SHIFT)'(drive_limit_r);
    if (val > lim)       drv_val = 16'(lim);
    else if (val < -lim) drv_val = 16'(-lim);
    else                 drv_val = 16'(val);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_acc) state_nxt = S_SPEED;
      S_SPEED:    state_nxt = S_SPD_WAIT;
      S_SPD_WAIT: if (mac_sts.done) state_nxt = S_ERR;
      S_ERR:      state_nxt = S_P_WAIT;
      S_P_WAIT:   if (mac_sts.done) state_nxt = S_I_WAIT;
      S_I_WAIT:   if (mac_sts.done) state_nxt = d_on ? S_D_WAIT : S_FIN;
      S_D_WAIT:   if (mac_sts.done) state_nxt = S_FIN;
      S_FIN:      state_nxt = (wheel_r == WHEEL_W'(NUM_WHEELS-1)) ? S_DONE : S_SPEED;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // multiplier requests: speed, then p, i and (windowed) d products
  always_comb begin
    mac_req = '0;
    case (state_r)
      S_SPEED: begin
        mac_req.start  = 1'b1;
        mac_req.clear  = 1'b1;
        mac_req.mcand  = ACC_W'({1'b0, count_to_speed_r});
        mac_req.mplier = rem_mag;
      end
      S_ERR: begin
        mac_req.start  = 1'b1;
        mac_req.clear  = 1'b1;
        mac_req.mcand  = ACC_W'(err_now_r[wheel_r]);
        mac_req.mplier = gain_prop_r;
      end
      S_P_WAIT: begin
        mac_req.start  = mac_sts.done;
        mac_req.mcand  = ACC_W'(err_sum_r[wheel_r]);
        mac_req.mplier = gain_integ_r;
      end
      S_I_WAIT: begin
        mac_req.start  = mac_sts.done && d_on;
        mac_req.mcand  = ACC_W'(d_term);
        mac_req.mplier = gain_deriv_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wheel_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        err_now_r[i]   <= '0;
        err_prev_r[i]  <= '0;
        err_prev2_r[i] <= '0;
        err_sum_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (in_acc) wheel_r <= '0;
      else if (state_r == S_FIN) wheel_r <= wheel_r + 1'b1;
      if (state_r == S_SPD_WAIT && mac_sts.done) begin
        err_prev2_r[wheel_r] <= err_prev_r[wheel_r];
        err_prev_r[wheel_r]  <= err_now_r[wheel_r];
        err_now_r[wheel_r]   <= e_new;
        err_sum_r[wheel_r]   <= sum_new;
      end
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)               out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cnt_r[0] <= in_enc_count_0;
      cnt_r[1] <= in_enc_count_1;
      cnt_r[2] <= in_enc_count_2;
      cnt_r[3] <= in_enc_count_3;
      tgt_r[0] <= in_target_0;
      tgt_r[1] <= in_target_1;
      tgt_r[2] <= in_target_2;
      tgt_r[3] <= in_target_3;
    end
    if (state_r == S_SPEED) rneg_r <= rem[15];
    if (state_r == S_FIN) drv_r[wheel_r] <= drv_val;
    if (state_r == S_DONE && out_free) begin
      for (int i = 0; i < NUM_WHEELS; i++) dout_r[i] <= drv_r[i];
    end
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_drive_0 = dout_r[0];
  assign out_drive_1 = dout_r[1];
  assign out_drive_2 = dout_r[2];
  assign out_drive_3 = dout_r[3];

endmodule

@@ hw/rtl/fwpid_mac.sv @@
module fwpid_mac
  import fwpid_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_req_t                req,
  output mac_sts_t                sts,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] mcand_r, mcand_nxt;
  logic [MUL_W-1:0]        mplier_r, mplier_nxt;
  logic [STEP_W-1:0]       cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;

  // one multiplier bit per cycle, lsb first
  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (req.start) begin
      acc_nxt    = req.clear ? '0 : acc_r;
      mcand_nxt  = req.mcand;
      mplier_nxt = req.mplier;
      cnt_nxt    = '0;
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt  = mcand_r <<< 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r + 1'b1;
      if (cnt_r == {STEP_W{1'b1}}) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    cnt_r    <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign acc      = acc_r;

endmodule

@@ hw/rtl/fwpid_checker.sv @@
module fwpid_checker
  import fwpid_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_drive_0,
  input logic signed [15:0] out_drive_1
);

  // output beat held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive_0) && $stable(out_drive_1))
    else $error("out beat changed under stall");

  // one tick in flight: accept closes the input side
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // result cannot appear the cycle after accept
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result without computation");

  // symmetric clamp never yields the most negative code
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive_0 != 16'sh8000 && out_drive_1 != 16'sh8000)
    else $error("drive outside symmetric clamp");

endmodule

bind four_wheel_pid_speed_control fwpid_checker u_fwpid_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_drive_0 (out_drive_0),
  .out_drive_1 (out_drive_1)
);

@@ verif/pid_checker.sv @@
`timescale 1ns / 1ps

module pid_checker
  import fwpid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [3:0][15:0]      in_counts,
  input  logic [3:0][15:0]      in_targets,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [3:0][15:0]      out_drives,
  output int                    fail_count,
  output int                    pending
);

  localparam int WIN = 4;

  logic [15:0] kp, ki, kd, win;
  logic [14:0] lim;
  logic [23:0] cts;

  longint e0[WIN];
  longint e1[WIN];
  longint e2[WIN];
  longint esum[WIN];

  logic [3:0][15:0] drive_q[$];
  int               beats_out;

  assign pending = drive_q.size();

  function automatic longint clamp_bits(longint x, int w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic longint shr_toward_zero(longint x, int s);
    if (x < 0) return -((-x) >>> s);
    return x >>> s;
  endfunction

  // one control tick: update the error history and work out the four drives
  function automatic logic [3:0][15:0] pid_tick(logic [3:0][15:0] cnt, logic [3:0][15:0] tgt);
    logic [3:0][15:0] drv;
    longint rem, spd, e, acc, val;
    for (int w = 0; w < WIN; w++) begin
      rem = longint'($signed(cnt[w])) % COUNT_WRAP;
      spd = shr_toward_zero(rem * longint'(cts), SPEED_SHIFT);
      e2[w] = e1[w];
      e1[w] = e0[w];
      e = clamp_bits(longint'($signed(tgt[w])) * (64'sd1 <<< FRAC_BITS) - spd, ERR_W);
      e0[w] = e;
      esum[w] = clamp_bits(esum[w] + e, SUM_W);
      acc = longint'(kp) * e + longint'(ki) * esum[w];
      if (e < (longint'(win) <<< FRAC_BITS))
        acc += longint'(kd) * (e - 2 * e1[w] + e2[w]);
      val = shr_toward_zero(acc, OUT_SHIFT);
      if (val > longint'(lim)) val = longint'(lim);
      if (val < -longint'(lim)) val = -longint'(lim);
      drv[w] = val[15:0];
    end
    return drv;
  endfunction

  task automatic report(string what);
    $display("[%0t] checker: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    beats_out = 0;
  end

  always @(posedge clk) begin
    logic [3:0][15:0] want;
    if (!rst_n) begin
      kp = 16'd614; ki = 16'd256; kd = 16'd0;
      lim = 15'd999; cts = 24'd212323; win = 16'd100;
      for (int w = 0; w < WIN; w++) begin
        e0[w] = 0; e1[w] = 0; e2[w] = 0; esum[w] = 0;
      end
      drive_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_GAIN_PROP:      kp  = cfg_wdata[15:0];
          REG_GAIN_INTEG:     ki  = cfg_wdata[15:0];
          REG_GAIN_DERIV:     kd  = cfg_wdata[15:0];
          REG_DRIVE_LIMIT:    lim = cfg_wdata[14:0];
          REG_COUNT_TO_SPEED: cts = cfg_wdata[23:0];
          REG_DERIV_WINDOW:   win = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        drive_q.push_back(pid_tick(in_counts, in_targets));
      if (out_valid && !out_stall) begin
        beats_out++;
        if (drive_q.size() == 0) begin
          report("result beat with no tick pending");
        end else begin
          want = drive_q.pop_front();
          for (int w = 0; w < WIN; w++)
            if (out_drives[w] !== want[w])
              report($sformatf("beat %0d wheel %0d drive %0d, predicted %0d", beats_out, w,
                               $signed(out_drives[w]), $signed(want[w])));
        end
      end
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import fwpid_pkg::*;

  localparam int IDLE_LIMIT = 6000;  // must cover one tick's computation plus receiver stalls
  localparam int SAT_TICKS  = 60;    // run of max-error ticks to build a large integral

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [3:0][15:0]      counts;
  logic [3:0][15:0]      targets;
  logic                  out_valid;
  logic                  out_stall;
  logic [3:0][15:0]      drives;
  int                    fail_count;
  int                    pending;

  // stimulus-side copy of the speed factor, used to aim counts near the target
  logic [23:0] speed_factor;
  int          ticks_sent;
  int          phases;
  int          burst_left;
  int          idle_cycles;

  four_wheel_pid_speed_control u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_enc_count_0 (counts[0]),
    .in_enc_count_1 (counts[1]),
    .in_enc_count_2 (counts[2]),
    .in_enc_count_3 (counts[3]),
    .in_target_0    (targets[0]),
    .in_target_1    (targets[1]),
    .in_target_2    (targets[2]),
    .in_target_3    (targets[3]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_drive_0    (drives[0]),
    .out_drive_1    (drives[1]),
    .out_drive_2    (drives[2]),
    .out_drive_3    (drives[3])
  );

  pid_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_counts  (counts),
    .in_targets (targets),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_drives (drives),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // receiver stall: mode is redrawn when its countdown runs out (none, light, bursty)
  int stall_mode;
  int stall_cyc;
  always @(posedge clk) begin
    if (stall_cyc == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_cyc  <= $urandom_range(200, 900);
    end else begin
      stall_cyc <= stall_cyc - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ((stall_cyc % 32) < 20);
    endcase
  end

  // watchdog on cycles with no beat on either channel and no register write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // present one tick and hold it until the block takes it; stall sampled at negedge
  task automatic send_tick(input logic [3:0][15:0] c, input logic [3:0][15:0] t);
    logic st;
    in_valid <= 1'b1;
    counts   <= c;
    targets  <= t;
    do begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
    end while (st);
    ticks_sent++;
    // end of burst: draw a new burst length; half the time drop valid and sit out a random gap
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 6);
      if ($urandom_range(0, 1) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 300)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0 || out_valid);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx == REG_COUNT_TO_SPEED) speed_factor = val;
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    phases++;
  endtask

  // one full register set, written between phases
  task automatic load_regs(input logic [15:0] p, input logic [15:0] i, input logic [15:0] d,
                           input logic [23:0] lim, input logic [23:0] cts,
                           input logic [15:0] win);
    wait_idle();
    write_reg(REG_GAIN_PROP, {8'h00, p});
    write_reg(REG_GAIN_INTEG, {8'h00, i});
    write_reg(REG_GAIN_DERIV, {8'h00, d});
    write_reg(REG_DRIVE_LIMIT, lim);
    write_reg(REG_COUNT_TO_SPEED, cts);
    write_reg(REG_DERIV_WINDOW, {8'h00, win});
    end_writes();
  endtask

  function automatic logic [15:0] full_rand();
    return 16'($urandom);
  endfunction

  // mostly plausible ticks: counts near what the target implies, plus some noise items
  task automatic random_ticks(input int n);
    logic [3:0][15:0] c;
    logic [3:0][15:0] t;
    int tv;
    longint cv;
    for (int k = 0; k < n; k++) begin
      for (int w = 0; w < 4; w++) begin
        if ($urandom_range(0, 4) == 0) begin
          c[w] = full_rand();
          t[w] = full_rand();
        end else begin
          tv = $urandom_range(0, 4000) - 2000;
          cv = (speed_factor == 0) ? 0 : (longint'(tv) * 65536) / longint'(speed_factor);
          cv += longint'($urandom_range(0, 60)) - 30;
          if (cv > 32767) cv = 32767;
          if (cv < -32768) cv = -32768;
          c[w] = cv[15:0];
          t[w] = tv[15:0];
        end
      end
      send_tick(c, t);
    end
  endtask

  logic [3:0][15:0] dc[$];
  logic [3:0][15:0] dt[$];

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    counts     = '0;
    targets    = '0;
    out_stall  = 1'b0;
    stall_mode = 0;
    stall_cyc  = 0;
    idle_cycles  = 0;
    ticks_sent   = 0;
    phases       = 0;
    burst_left   = 0;
    speed_factor = 24'd212323;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: count and target extremes, wrap boundaries, zero
    dc = '{{16'h8000, 16'h7fff, 16'd30000, -16'sd30000},
           {16'd29999, -16'sd29999, 16'd0, 16'd1},
           {16'hffff, 16'd30001, -16'sd30001, 16'h8000},
           {16'd0, 16'd0, 16'd0, 16'd0},
           {16'd100, -16'sd100, 16'd500, -16'sd500}};
    dt = '{{16'h7fff, 16'h8000, 16'd0, 16'h7fff},
           {16'h8000, 16'h7fff, 16'hffff, 16'd1},
           {16'd0, 16'd0, 16'h7fff, 16'h8000},
           {16'd300, -16'sd300, 16'd50, 16'd99},
           {16'd0, 16'd0, 16'd0, 16'd0}};
    foreach (dc[k]) send_tick(dc[k], dt[k]);

    // every register at its top, derivative window at its widest: error saturation both ways
    load_regs(16'hffff, 16'hffff, 16'hffff, 24'h007fff, 24'hffffff, 16'hffff);
    foreach (dc[k]) send_tick(dc[k], dt[k]);

    // zero drive limit, plus masked bits and writes to unused indexes
    wait_idle();
    write_reg(REG_DRIVE_LIMIT, 24'hff8000);
    write_reg(REG_GAIN_PROP, 24'hab1234);
    write_reg(3'd6, 24'hffffff);
    write_reg(3'd7, 24'h000000);
    end_writes();
    foreach (dc[k]) send_tick(dc[k], dt[k]);

    // derivative window, speed factor, drive limit and all gains at zero
    load_regs(16'd0, 16'd0, 16'd0, 24'd0, 24'd0, 16'd0);
    foreach (dc[k]) send_tick(dc[k], dt[k]);

    // back to defaults for plausible random ticks
    load_regs(16'd614, 16'd256, 16'd0, 24'd999, 24'd212323, 16'd100);
    random_ticks(400);

    load_regs(16'd800, 16'd40, 16'd1200, 24'd32767, 24'd212323, 16'd300);
    random_ticks(300);

    for (int ph = 0; ph < 4; ph++) begin
      load_regs(full_rand(), full_rand(), full_rand(), 24'($urandom_range(0, 32767)),
                24'($urandom), full_rand());
      random_ticks(250);
    end

    // build a large positive integral sum with max error on every wheel
    load_regs(16'd0, 16'hffff, 16'd0, 24'h007fff, 24'hffffff, 16'd0);
    burst_left = 1 << 30;
    for (int k = 0; k < SAT_TICKS; k++)
      send_tick({4{-16'sd29999}}, {4{16'h7fff}});
    burst_left = 0;
    load_regs(16'd614, 16'd256, 16'd300, 24'd999, 24'd212323, 16'd100);
    random_ticks(100);

    wait_idle();
    repeat (300) @(posedge clk);
    $display("testbench: %0d ticks over %0d register settings, incl. clamp, window,",
             ticks_sent, phases);
    $display("testbench: error saturation, large integral, bursty sender, stalled receiver");
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
